// ===== hdl/rar_pkg.sv =====
package rar_pkg;

	typedef enum logic [1:0] {
		FUNC_ADD = 2'd0,
		FUNC_SUB = 2'd1,
		FUNC_MUL = 2'd2,
		FUNC_DIV = 2'd3
	} func_t;

	localparam int MAG_W = 63;
	localparam int DEN_W = 62;

endpackage

// ===== hdl/rational_arith_reduce_unit.sv =====
// Rational arithmetic unit with reduction to lowest terms.
// Usage: present func and the four operands with start high while busy is
// low; the item is taken at that edge and busy rises. One shared 64-bit
// subtract/compare unit then works the item: products are formed by
// shift-and-add (one operand bit per cycle), a binary GCD reduces the
// numerator and denominator, and two restoring divisions (one quotient bit
// per cycle) divide both by the gcd.
// Sequence: the products, three for add and subtract (two numerator terms
// and the denominator) and two for multiply and divide; the combine and
// check states; the GCD (strip common twos, then subtract, swap and halve
// steps); the two divisions, numerator then denominator; and the load of
// the result in ST_OUT. Zero results or zero denominators skip the GCD and
// divisions. One item is in flight at a time: a new item may be taken in
// the cycle that done is high.
// The result is shown for one cycle with done high; the receiver cannot
// stall, so no result is held back. Reset clears busy and done; no item is
// in flight after reset.
module rational_arith_reduce_unit #(
	parameter int OPERAND_BITS = 31
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [1:0]              func,
	input  logic [30:0]             num_left,
	input  logic [30:0]             den_left,
	input  logic [30:0]             num_right,
	input  logic [30:0]             den_right,
	output logic                    done,
	output logic signed [63:0]      res_num,
	output logic [61:0]             res_den,
	output logic                    zero_den_error
);

	localparam int CW = 7;

	typedef enum logic [3:0] {
		ST_IDLE, ST_MUL_A, ST_MUL_B, ST_MUL_C, ST_COMB, ST_CHECK,
		ST_GCD_SH, ST_GCD_ST, ST_DIV_N, ST_DIV_D, ST_OUT
	} state_t;

	state_t state_q;
	logic [1:0]  func_q;
	logic [OPERAND_BITS-1:0] nl_q, dl_q, nr_q, dr_q;
	logic [63:0] acc_q, p_q, q_q, den_q, mag_q;
	logic [63:0] u_q, v_q;
	logic [CW-1:0] k_q, cnt_q;
	logic [63:0] rem_q, quo_q, dvd_q;
	logic neg_q;

	// shared unit: one 64-bit subtract with borrow out
	logic [63:0] sh_a, sh_b;
	logic [64:0] sh_diff;
	assign sh_diff = {1'b0, sh_a} - {1'b0, sh_b};

	logic [63:0] gcd_g;
	assign gcd_g = u_q << k_q;
	logic [63:0] rem_sh;
	assign rem_sh = {rem_q[62:0], dvd_q[63]};

	always_comb begin
		sh_a = acc_q;
		sh_b = 64'd0;
		case (state_q)
			ST_COMB: begin
				sh_a = p_q;
				sh_b = q_q;
			end
			ST_GCD_ST: begin
				sh_a = v_q;
				sh_b = u_q;
			end
			ST_DIV_N, ST_DIV_D: begin
				sh_a = rem_sh;
				sh_b = gcd_g;
			end
			default: begin
				sh_a = acc_q;
				sh_b = 64'd0;
			end
		endcase
	end

	logic [OPERAND_BITS-1:0] mx, my;
	logic [63:0] mul_add;
	always_comb begin
		// first numerator term, then second term or denominator, then denominator
		mx = '0;
		my = '0;
		case (state_q)
			ST_MUL_A: begin
				mx = (func_q == rar_pkg::FUNC_MUL) ? nr_q : dr_q;
				my = nl_q;
			end
			ST_MUL_B: begin
				mx = (func_q == rar_pkg::FUNC_MUL) ? dr_q : nr_q;
				my = dl_q;
			end
			ST_MUL_C: begin
				mx = dr_q;
				my = dl_q;
			end
			default: begin
				mx = '0;
				my = '0;
			end
		endcase
		mul_add = mx[cnt_q[$clog2(OPERAND_BITS+1)-1:0]]
			? (64'(my) << cnt_q) : 64'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						func_q <= func;
						nl_q <= num_left[OPERAND_BITS-1:0];
						dl_q <= den_left[OPERAND_BITS-1:0];
						nr_q <= num_right[OPERAND_BITS-1:0];
						dr_q <= den_right[OPERAND_BITS-1:0];
						acc_q <= 64'd0;
						cnt_q <= '0;
						state_q <= ST_MUL_A;
					end
				end
				ST_MUL_A: begin
					if (cnt_q == CW'(OPERAND_BITS-1)) begin
						cnt_q <= '0;
						p_q <= acc_q + mul_add;
						acc_q <= 64'd0;
						state_q <= ST_MUL_B;
					end else begin
						acc_q <= acc_q + mul_add;
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_MUL_B: begin
					if (cnt_q == CW'(OPERAND_BITS-1)) begin
						cnt_q <= '0;
						if (func_q inside {rar_pkg::FUNC_ADD, rar_pkg::FUNC_SUB}) begin
							q_q <= acc_q + mul_add;
							acc_q <= 64'd0;
							state_q <= ST_MUL_C;
						end else begin
							acc_q <= acc_q + mul_add;
							state_q <= ST_COMB;
						end
					end else begin
						acc_q <= acc_q + mul_add;
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_MUL_C: begin
					acc_q <= acc_q + mul_add;
					if (cnt_q == CW'(OPERAND_BITS-1)) begin
						cnt_q <= '0;
						state_q <= ST_COMB;
					end else cnt_q <= cnt_q + CW'(1);
				end
				ST_COMB: begin
					// acc holds the denominator, p_q the numerator (p_q and q_q the two terms for add and subtract)
					neg_q <= (func_q == rar_pkg::FUNC_SUB) && sh_diff[64];
					den_q <= acc_q;
					case (func_q)
						rar_pkg::FUNC_ADD: mag_q <= p_q + q_q;
						rar_pkg::FUNC_SUB: begin
							if (!sh_diff[64]) mag_q <= sh_diff[63:0];
							else mag_q <= q_q - p_q;
						end
						default: mag_q <= p_q;
					endcase
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					u_q <= mag_q;
					v_q <= den_q;
					k_q <= '0;
					if (den_q == 64'd0 || mag_q == 64'd0) state_q <= ST_OUT;
					else state_q <= ST_GCD_SH;
				end
				ST_GCD_SH: begin
					// strip common twos, then make u and v odd
					if (!u_q[0] && !v_q[0]) begin
						u_q <= u_q >> 1;
						v_q <= v_q >> 1;
						k_q <= k_q + CW'(1);
					end else if (!u_q[0]) u_q <= u_q >> 1;
					else if (!v_q[0]) v_q <= v_q >> 1;
					else state_q <= ST_GCD_ST;
				end
				ST_GCD_ST: begin
					if (v_q == 64'd0) begin
						rem_q <= 64'd0;
						quo_q <= 64'd0;
						dvd_q <= mag_q;
						cnt_q <= '0;
						state_q <= ST_DIV_N;
					end else if (!v_q[0]) v_q <= v_q >> 1;
					else if (sh_diff[64]) begin
						// v below u: swap so that v holds the larger value
						u_q <= v_q;
						v_q <= u_q;
					end else v_q <= sh_diff[63:0];
				end
				ST_DIV_N, ST_DIV_D: begin
					if (cnt_q == CW'(63)) begin
						cnt_q <= '0;
						rem_q <= 64'd0;
						quo_q <= 64'd0;
						if (state_q == ST_DIV_N) begin
							mag_q <= {quo_q[62:0], !sh_diff[64]};
							dvd_q <= den_q;
							state_q <= ST_DIV_D;
						end else begin
							den_q <= {quo_q[62:0], !sh_diff[64]};
							state_q <= ST_OUT;
						end
					end else begin
						cnt_q <= cnt_q + CW'(1);
						dvd_q <= dvd_q << 1;
						if (!sh_diff[64]) begin
							rem_q <= sh_diff[63:0];
							quo_q <= {quo_q[62:0], 1'b1};
						end else begin
							rem_q <= rem_sh;
							quo_q <= {quo_q[62:0], 1'b0};
						end
					end
				end
				ST_OUT: begin
					done <= 1'b1;
					zero_den_error <= (den_q == 64'd0);
					if (den_q == 64'd0) begin
						res_num <= 64'sd0;
						res_den <= 62'd0;
					end else if (mag_q == 64'd0) begin
						res_num <= 64'sd0;
						res_den <= 62'd1;
					end else begin
						res_num <= neg_q ? -$signed(mag_q) : $signed(mag_q);
						res_den <= den_q[61:0];
					end
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);

	a_done_after_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |=> done) else $error("done missing");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("start not taken");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && zero_den_error) |-> (res_den == 62'd0)) else $error("bad err");

endmodule
